// ===== rtl/rgbe_pkg.sv =====
package rgbe_pkg;

   // float32(1/255) significand, hidden bit included; value is SIG * 2^-31
   localparam logic [23:0] RCP_255_SIG = 24'h808081;
   // unbiased-to-half offset: 23 (lead base) + 127 - 128 (scale) - 112 (rebias) - 31
   localparam logic [10:0] EXP_OFFSET  = 11'd121;
   localparam logic [15:0] HALF_INF    = 16'h7c00;
   localparam logic [23:0] HALF_ROUND  = 24'h002000;
   localparam int          CHANNELS    = 3;

   typedef logic [7:0]  byte_type;
   typedef logic [31:0] prod_type;
   typedef logic [15:0] half_type;

   typedef struct packed {
      logic              zero;
      logic signed [10:0] expo;   // half-biased exponent before narrowing
      logic [22:0]       frac;
   } norm_type;

   // Normalize the exact product, round to float32 (nearest even) and apply the scale.
   function automatic norm_type normalize(input prod_type prod, input byte_type sexp);
      logic [3:0]  lead;
      prod_type    shifted;
      prod_type    below;
      logic        guard;
      logic        sticky;
      logic        up;
      logic [24:0] sum;
      logic        carry;
      logic [10:0] ex;
      norm_type    r;
      lead = 4'd0;
      for (int i = 0; i < 9; i++) begin
         if (prod[23 + i]) begin
            lead = 4'(i);
         end
      end
      shifted = prod >> lead;
      below   = prod & ((32'd1 << lead) - 32'd1);
      guard   = |(below & (32'd1 << (lead - 4'd1)));
      sticky  = |(below & ((32'd1 << (lead - 4'd1)) - 32'd1));
      up      = guard & (sticky | shifted[0]);
      sum     = {1'b0, shifted[23:0]} + 25'(up);
      carry   = sum[24];
      r.frac  = carry ? 23'd0 : sum[22:0];
      ex      = {7'd0, lead} + {10'd0, carry} + {3'd0, sexp} - EXP_OFFSET;
      r.expo  = $signed(ex);
      r.zero  = (prod == '0);
      return r;
   endfunction

   // Narrow to binary16, round half up on the first dropped bit.
   function automatic half_type narrow(input norm_type n);
      logic [23:0]        m;
      logic [4:0]         sh;
      logic signed [10:0] e;
      half_type           h;
      e = n.expo;
      m = 24'd0;
      sh = 5'd0;
      if (n.zero || (e < -11'sd10)) begin
         h = 16'd0;
      end else if (e <= 11'sd0) begin
         sh = 5'(11'sd1 - e);
         m  = {1'b1, n.frac} >> sh;
         if (m[12]) begin
            m = m + HALF_ROUND;
         end
         h = {5'd0, m[23:13]};
      end else begin
         m = {1'b0, n.frac};
         if (m[12]) begin
            m = m + HALF_ROUND;
         end
         if (m[23]) begin
            m = 24'd0;
            e = e + 11'sd1;
         end
         if (e > 11'sd30) begin
            h = HALF_INF;
         end else begin
            h = {1'b0, e[4:0], m[22:13]};
         end
      end
      return h;
   endfunction

endpackage

// ===== rtl/rgbe_mul.sv =====
module rgbe_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_stall,
   input  rgbe_pkg::byte_type           in_byte [rgbe_pkg::CHANNELS],
   input  rgbe_pkg::byte_type           in_sexp,
   output logic                         out_valid,
   input  logic                         out_stall,
   output rgbe_pkg::prod_type           out_prod [rgbe_pkg::CHANNELS],
   output rgbe_pkg::byte_type           out_sexp
);
   import rgbe_pkg::*;

   logic     valid_ff;
   prod_type prod_ff [CHANNELS];
   byte_type sexp_ff;
   logic     load;

   assign in_stall = valid_ff & out_stall;
   assign load     = in_valid & ~in_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int c = 0; c < CHANNELS; c++) begin
            prod_ff[c] <= 32'(in_byte[c]) * 32'(RCP_255_SIG);
         end
         sexp_ff <= in_sexp;
      end
   end

   assign out_valid = valid_ff;
   assign out_prod  = prod_ff;
   assign out_sexp  = sexp_ff;
endmodule

// ===== rtl/rgbe_norm.sv =====
module rgbe_norm (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_stall,
   input  rgbe_pkg::prod_type           in_prod [rgbe_pkg::CHANNELS],
   input  rgbe_pkg::byte_type           in_sexp,
   output logic                         out_valid,
   input  logic                         out_stall,
   output rgbe_pkg::norm_type           out_norm [rgbe_pkg::CHANNELS]
);
   import rgbe_pkg::*;

   logic     valid_ff;
   norm_type norm_ff [CHANNELS];
   logic     load;

   assign in_stall = valid_ff & out_stall;
   assign load     = in_valid & ~in_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int c = 0; c < CHANNELS; c++) begin
            norm_ff[c] <= normalize(in_prod[c], in_sexp);
         end
      end
   end

   assign out_valid = valid_ff;
   assign out_norm  = norm_ff;
endmodule

// ===== rtl/rgbe_narrow.sv =====
module rgbe_narrow (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_stall,
   input  rgbe_pkg::norm_type           in_norm [rgbe_pkg::CHANNELS],
   output logic                         out_valid,
   input  logic                         out_stall,
   output rgbe_pkg::half_type           out_half [rgbe_pkg::CHANNELS]
);
   import rgbe_pkg::*;

   logic     valid_ff;
   half_type half_ff [CHANNELS];
   logic     load;

   assign in_stall = valid_ff & out_stall;
   assign load     = in_valid & ~in_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int c = 0; c < CHANNELS; c++) begin
            half_ff[c] <= narrow(in_norm[c]);
         end
      end
   end

   assign out_valid = valid_ff;
   assign out_half  = half_ff;
endmodule

// ===== rtl/rgbe_pixel_to_half_float.sv =====
// RGBE pixel to binary16 converter.
// Input channel (req_): one RGBE pixel per transaction, three mantissa bytes
// and the shared exponent byte. Output channel (rsp_): three binary16 bit
// patterns, one transaction per pixel, in arrival order.
// Each channel is byte * float32(1/255), scaled by 2^(exponent-128) in float32,
// then narrowed to half with round half up; tiny values give zero and large
// values give +infinity.
// Structure: three register stages (multiply, normalize/round, narrow); a pixel
// passes the multiply, normalize and narrow registers in turn, and rsp_valid
// rises once it is held in the narrow register.
// Throughput: one pixel per cycle while rsp_stall is low; a stage register
// takes a pixel whenever it is empty or its content moves on in the same cycle.
// Reset clears the stage valid bits; nothing is in flight afterwards.
// When the receiver holds rsp_stall the last stage holds its result and the
// earlier stages keep filling; req_stall rises only once every stage is full.
module rgbe_pixel_to_half_float (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_shared_exponent,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_red_half,
   output logic [15:0] rsp_green_half,
   output logic [15:0] rsp_blue_half
);
   import rgbe_pkg::*;

   byte_type in_byte [CHANNELS];
   prod_type prod    [CHANNELS];
   norm_type norm    [CHANNELS];
   half_type half    [CHANNELS];
   byte_type sexp;
   logic     mul_valid;
   logic     mul_stall;
   logic     norm_valid;
   logic     norm_stall;

   assign in_byte[0] = req_red;
   assign in_byte[1] = req_green;
   assign in_byte[2] = req_blue;

   rgbe_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_byte   (in_byte),
      .in_sexp   (req_shared_exponent),
      .out_valid (mul_valid),
      .out_stall (mul_stall),
      .out_prod  (prod),
      .out_sexp  (sexp)
   );

   rgbe_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_stall  (mul_stall),
      .in_prod   (prod),
      .in_sexp   (sexp),
      .out_valid (norm_valid),
      .out_stall (norm_stall),
      .out_norm  (norm)
   );

   rgbe_narrow u_narrow (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_valid),
      .in_stall  (norm_stall),
      .in_norm   (norm),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_half  (half)
   );

   assign rsp_red_half   = half[0];
   assign rsp_green_half = half[1];
   assign rsp_blue_half  = half[2];
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import rgbe_pkg::*;

   typedef struct packed {
      half_type red;
      half_type green;
      half_type blue;
   } halves_type;

   // Predicts each channel from exact integer arithmetic: byte times the
   // float32 significand of 1/255, rounded to 24 bits, scaled, then narrowed.
   class half_scoreboard;
      halves_type pending[$];
      int         errors;

      function new();
         errors = 0;
      endfunction

      function half_type channel_to_half(logic [7:0] value, logic [7:0] sexp);
         logic [63:0] exact;
         logic [63:0] sig;
         logic [63:0] rest;
         logic [63:0] half_point;
         int          msb;
         int          drop;
         int          hexp;
         logic [23:0] mant;
         exact = 64'(value) * 64'h808081;
         if (exact == 0) begin
            return 16'h0000;
         end
         msb = 0;
         for (int i = 0; i < 40; i++) begin
            if (exact[i]) msb = i;
         end
         drop = msb - 23;
         sig  = exact;
         if (drop > 0) begin
            sig        = exact >> drop;
            rest       = exact & ((64'd1 << drop) - 1);
            half_point = 64'd1 << (drop - 1);
            // round to nearest, ties to even
            if (rest > half_point || (rest == half_point && sig[0])) sig = sig + 1;
            if (sig[24]) begin
               sig = sig >> 1;
               msb = msb + 1;
            end
         end
         hexp = msb + int'(sexp) - 144;
         if (hexp < -10) begin
            return 16'h0000;
         end
         if (hexp <= 0) begin
            mant = sig[23:0] >> (1 - hexp);
            if (mant[12]) mant = mant + 24'h002000;
            return {5'd0, mant[23:13]};
         end
         mant = {1'b0, sig[22:0]};
         if (mant[12]) mant = mant + 24'h002000;
         if (mant[23]) begin
            mant = 24'd0;
            hexp = hexp + 1;
         end
         if (hexp > 30) return HALF_INF;
         return {1'b0, 5'(hexp), mant[22:13]};
      endfunction

      function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] e);
         halves_type h;
         h.red   = channel_to_half(r, e);
         h.green = channel_to_half(g, e);
         h.blue  = channel_to_half(b, e);
         pending.push_back(h);
      endfunction

      function void check_pixel(half_type r, half_type g, half_type b);
         halves_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected transaction red %h green %h blue %h", $time, r, g, b);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (r !== want.red) begin
            $display("%0t: red expected %h actual %h", $time, want.red, r);
            errors++;
         end
         if (g !== want.green) begin
            $display("%0t: green expected %h actual %h", $time, want.green, g);
            errors++;
         end
         if (b !== want.blue) begin
            $display("%0t: blue expected %h actual %h", $time, want.blue, b);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_red;
   logic [7:0]  req_green;
   logic [7:0]  req_blue;
   logic [7:0]  req_shared_exponent;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_red_half;
   logic [15:0] rsp_green_half;
   logic [15:0] rsp_blue_half;

   half_scoreboard scoreboard;
   logic           stimulus_done;

   rgbe_pixel_to_half_float u_top (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Present one pixel at the falling edge and hold it until accepted.
   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] e);
      int gap;
      gap = idle_length();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid           <= 1'b1;
      req_red             <= r;
      req_green           <= g;
      req_blue            <= b;
      req_shared_exponent <= e;
      do @(posedge clock); while (req_stall);
      scoreboard.note_pixel(r, g, b, e);
   endtask

   function automatic logic [7:0] pick_exponent();
      if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(98, 148));
   endfunction

   initial begin
      logic [7:0] edge_bytes[5] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd255};
      logic [7:0] edge_exps[14] = '{8'd0, 8'd102, 8'd103, 8'd105, 8'd110, 8'd113, 8'd114,
                                    8'd120, 8'd128, 8'd135, 8'd143, 8'd144, 8'd145, 8'd255};
      scoreboard          = new();
      stimulus_done       = 1'b0;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_red             = 8'd0;
      req_green           = 8'd0;
      req_blue            = 8'd0;
      req_shared_exponent = 8'd0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // extremes: exponent boundaries around zero, subnormal and overflow
      for (int i = 0; i < 14; i++) begin
         send_pixel(edge_bytes[i % 5], edge_bytes[(i + 2) % 5], edge_bytes[(i + 4) % 5],
                    edge_exps[i]);
      end
      send_pixel(8'd255, 8'd255, 8'd255, 8'd143);
      send_pixel(8'd1, 8'd2, 8'd3, 8'd103);
      send_pixel(8'd170, 8'd85, 8'd254, 8'd112);
      for (int i = 0; i < 1500; i++) begin
         send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), pick_exponent());
      end
      @(negedge clock);
      req_valid     <= 1'b0;
      stimulus_done <= 1'b1;
   end

   // Receiver: alternate runs of acceptance and stall.
   initial begin
      int run;
      rsp_stall = 1'b0;
      forever begin
         run = $urandom_range(0, 1) ? $urandom_range(1, 20) : $urandom_range(50, 120);
         repeat (run) begin
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         run = idle_length();
         repeat (run) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         scoreboard.check_pixel(rsp_red_half, rsp_green_half, rsp_blue_half);
      end
   end

   initial begin
      wait (stimulus_done === 1'b1);
      while (scoreboard.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (scoreboard.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
